>>> src/assert_macros.svh
// assertion macros for the checker file
// expects signals named clk and arst_n in the calling scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle as the antecedent
`define PIDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/pidc_pkg.sv
// shared widths, register map, op codes and config struct of the pid step block
// no dependencies
package pidc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = 24;
	localparam int INTEG_W  = 32;
	localparam int DERIV_W  = ERR_W + 1;
	localparam int GAIN_W   = 16;
	localparam int DRIVE_W  = 32;
	localparam int ACC_W    = DRIVE_W + 3;
	localparam int MUL_A_W  = INTEG_W + 1;
	localparam int MUL_B_W  = 19;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic signed [MUL_B_W-1:0] TRAP_K    = MUL_B_W'(167772);
	localparam logic signed [PROD_W-1:0]  ERR_RND   = PROD_W'(128);
	localparam logic signed [PROD_W-1:0]  INTEG_RND = PROD_W'(32768);
	localparam logic [GAIN_W-1:0]         SCALE_RST = GAIN_W'(256);

	typedef enum logic [1:0] {
		REG_PROP_GAIN   = 2'd0,
		REG_INTEG_GAIN  = 2'd1,
		REG_DERIV_GAIN  = 2'd2,
		REG_ERROR_SCALE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [GAIN_W-1:0]        error_scale;
	} cfg_t;

endpackage

>>> src/pidc_if.sv
// valid/ready channel interfaces for sample items and result items
// depends on pidc_pkg
interface pidc_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   op;
	logic signed [pidc_pkg::SAMPLE_W-1:0]   target;
	logic signed [pidc_pkg::SAMPLE_W-1:0]   measured;

	modport source (output valid, op, target, measured, input ready);
	modport sink (input valid, op, target, measured, output ready);
endinterface

interface pidc_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pidc_pkg::DRIVE_W-1:0]    drive;
	logic signed [pidc_pkg::ERR_W-1:0]      error_out;

	modport source (output valid, drive, error_out, input ready);
	modport sink (input valid, drive, error_out, output ready);
endinterface

>>> src/pid_controller_step.sv
// top level of the pid step block: sequencer around one shared multiplier
// depends on pidc_pkg, pidc_if, pidc_regs, pidc_mul
//
//  port    | direction | handshake        | payload
//  sample  | in        | valid / ready    | op, target, measured
//  result  | out       | valid / ready    | drive, error_out
//  apb     | in        | psel / penable   | paddr, pwdata, prdata
//
// an update item steps through err, esat, trap, integ, mp, mi, md and fin; a clear item goes straight to mp
// the multiplier is used five times per update: scale, trapezoid, three gains
// ready is high only in idle, so a new item is taken only after the last one has left fin
// a result waiting on the output holds the last step until it is taken
// reset clears the error, integral and derivative state, zeroes the gains and sets the error scale to 256
module pid_controller_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
	output logic [pidc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	pidc_sample_if.sink                   sample,
	pidc_result_if.source                 result
);

	typedef enum logic [3:0] {
		S_IDLE, S_ERR, S_ESAT, S_TRAP, S_INTEG, S_MP, S_MI, S_MD, S_FIN
	} state_t;

	state_t                                 state_q;
	pidc_pkg::cfg_t                         cfg;

	logic signed [pidc_pkg::SAMPLE_W:0]     diff_q;
	logic signed [pidc_pkg::ERR_W-1:0]      err_q;
	logic signed [pidc_pkg::DERIV_W-1:0]    sum_q;
	logic signed [pidc_pkg::DERIV_W-1:0]    deriv_q;
	logic signed [pidc_pkg::INTEG_W-1:0]    integ_q;
	logic signed [pidc_pkg::ACC_W-1:0]      acc_q;
	logic signed [pidc_pkg::DRIVE_W-1:0]    drive_q;
	logic signed [pidc_pkg::ERR_W-1:0]      err_out_q;
	logic                                   out_valid_q;

	logic                                   mul_en;
	logic signed [pidc_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [pidc_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [pidc_pkg::PROD_W-1:0]     prod_q;

	logic                                   in_acc;
	logic                                   out_free;
	logic signed [pidc_pkg::SAMPLE_W:0]     diff;
	logic signed [pidc_pkg::PROD_W-1:0]     esh;
	logic                                   e_ovf;
	logic signed [pidc_pkg::ERR_W-1:0]      e_sat;
	logic signed [pidc_pkg::PROD_W-1:0]     ish;
	logic signed [pidc_pkg::INTEG_W:0]      isum;
	logic signed [pidc_pkg::INTEG_W-1:0]    i_sat;
	logic signed [pidc_pkg::PROD_W-1:0]     psh8;
	logic signed [pidc_pkg::PROD_W-1:0]     psh16;
	logic signed [pidc_pkg::ACC_W-1:0]      total;
	logic                                   d_ovf;
	logic signed [pidc_pkg::DRIVE_W-1:0]    d_sat;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidc_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign sample.ready    = (state_q == S_IDLE);
	assign in_acc          = sample.valid && (state_q == S_IDLE);
	assign out_free        = !out_valid_q || result.ready;
	assign result.valid    = out_valid_q;
	assign result.drive    = drive_q;
	assign result.error_out = err_out_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_ERR: begin
				mul_a = pidc_pkg::MUL_A_W'(diff_q);
				mul_b = pidc_pkg::MUL_B_W'(cfg.error_scale);
			end
			S_TRAP: begin
				mul_a = pidc_pkg::MUL_A_W'(sum_q);
				mul_b = pidc_pkg::TRAP_K;
			end
			S_MP: begin
				mul_a = pidc_pkg::MUL_A_W'(err_q);
				mul_b = pidc_pkg::MUL_B_W'(cfg.prop_gain);
			end
			S_MI: begin
				mul_a = pidc_pkg::MUL_A_W'(integ_q);
				mul_b = pidc_pkg::MUL_B_W'(cfg.integ_gain);
			end
			S_MD: begin
				mul_a = pidc_pkg::MUL_A_W'(deriv_q);
				mul_b = pidc_pkg::MUL_B_W'(cfg.deriv_gain);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// input difference, and rounding, shifts and saturation on the registered product
	always_comb begin
		diff  = (pidc_pkg::SAMPLE_W + 1)'(sample.measured)
		      - (pidc_pkg::SAMPLE_W + 1)'(sample.target);
		esh   = (prod_q + pidc_pkg::ERR_RND) >>> 8;
		e_ovf = !(&esh[pidc_pkg::PROD_W-1:pidc_pkg::ERR_W-1])
		     && (|esh[pidc_pkg::PROD_W-1:pidc_pkg::ERR_W-1]);
		if (e_ovf) begin
			e_sat = esh[pidc_pkg::PROD_W-1] ? {1'b1, {(pidc_pkg::ERR_W-1){1'b0}}}
			                                : {1'b0, {(pidc_pkg::ERR_W-1){1'b1}}};
		end else begin
			e_sat = esh[pidc_pkg::ERR_W-1:0];
		end
		ish  = (prod_q + pidc_pkg::INTEG_RND) >>> 16;
		isum = (pidc_pkg::INTEG_W + 1)'(integ_q) + $signed(ish[pidc_pkg::INTEG_W:0]);
		if (isum[pidc_pkg::INTEG_W] != isum[pidc_pkg::INTEG_W-1]) begin
			i_sat = isum[pidc_pkg::INTEG_W] ? {1'b1, {(pidc_pkg::INTEG_W-1){1'b0}}}
			                                : {1'b0, {(pidc_pkg::INTEG_W-1){1'b1}}};
		end else begin
			i_sat = isum[pidc_pkg::INTEG_W-1:0];
		end
		psh8  = prod_q >>> 8;
		psh16 = prod_q >>> 16;
		total = acc_q + $signed(psh8[pidc_pkg::ACC_W-1:0]);
		d_ovf = !(&total[pidc_pkg::ACC_W-1:pidc_pkg::DRIVE_W-1])
		     && (|total[pidc_pkg::ACC_W-1:pidc_pkg::DRIVE_W-1]);
		if (d_ovf) begin
			d_sat = total[pidc_pkg::ACC_W-1] ? {1'b1, {(pidc_pkg::DRIVE_W-1){1'b0}}}
			                                 : {1'b0, {(pidc_pkg::DRIVE_W-1){1'b1}}};
		end else begin
			d_sat = total[pidc_pkg::DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= '0;
			integ_q     <= '0;
			deriv_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						diff_q <= diff;
						if (pidc_pkg::op_t'(sample.op) == pidc_pkg::OP_CLEAR) begin
							err_q   <= '0;
							integ_q <= '0;
							deriv_q <= '0;
							state_q <= S_MP;
						end else begin
							state_q <= S_ERR;
						end
					end
				end
				S_ERR:  state_q <= S_ESAT;
				S_ESAT: begin
					sum_q   <= pidc_pkg::DERIV_W'(e_sat) + pidc_pkg::DERIV_W'(err_q);
					deriv_q <= pidc_pkg::DERIV_W'(e_sat) - pidc_pkg::DERIV_W'(err_q);
					err_q   <= e_sat;
					state_q <= S_TRAP;
				end
				S_TRAP: state_q <= S_INTEG;
				S_INTEG: begin
					integ_q <= i_sat;
					state_q <= S_MP;
				end
				S_MP: state_q <= S_MI;
				S_MI: begin
					acc_q   <= $signed(psh8[pidc_pkg::ACC_W-1:0]);
					state_q <= S_MD;
				end
				S_MD: begin
					acc_q   <= acc_q + $signed(psh16[pidc_pkg::ACC_W-1:0]);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						drive_q     <= d_sat;
						err_out_q   <= err_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/pidc_regs.sv
// apb-style configuration registers: three gains and the error scale
// depends on pidc_pkg
module pidc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
	output logic [pidc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pidc_pkg::cfg_t                cfg
);

	pidc_pkg::cfg_t     cfg_q;
	pidc_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = pidc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.error_scale <= pidc_pkg::SCALE_RST;
		end else if (wr_en) begin
			unique case (idx)
				pidc_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= pwdata[15:0];
				pidc_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain  <= pwdata[15:0];
				pidc_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain  <= pwdata[15:0];
				pidc_pkg::REG_ERROR_SCALE: cfg_q.error_scale <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pidc_pkg::REG_PROP_GAIN:   prdata = {16'h0, cfg_q.prop_gain};
			pidc_pkg::REG_INTEG_GAIN:  prdata = {16'h0, cfg_q.integ_gain};
			pidc_pkg::REG_DERIV_GAIN:  prdata = {16'h0, cfg_q.deriv_gain};
			pidc_pkg::REG_ERROR_SCALE: prdata = {16'h0, cfg_q.error_scale};
			default:                   prdata = '0;
		endcase
	end

endmodule

>>> src/pidc_mul.sv
// shared signed multiplier with registered product, held when not enabled
// depends on pidc_pkg
module pidc_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [pidc_pkg::MUL_A_W-1:0] a,
	input  logic signed [pidc_pkg::MUL_B_W-1:0] b,
	output logic signed [pidc_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= pidc_pkg::PROD_W'(a) * pidc_pkg::PROD_W'(b);
		end
	end

endmodule

>>> src/pidc_checker.sv
// port-level checks of the pid step block, bound to the top level
// depends on pidc_pkg and assert_macros.svh
`include "assert_macros.svh"

module pidc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pidc_pkg::DRIVE_W-1:0] drive,
	input logic signed [pidc_pkg::ERR_W-1:0]   error_out
);

	// ready drops after an item is taken
	`PIDC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

	// ready only drops on an accepted item
	`PIDC_ASSERT_SAME(a_ready_fall, $fell(in_ready), $past(in_valid), "ready fell without item")

	// an idle block with no pending result produces nothing
	`PIDC_ASSERT_NEXT(a_no_spurious, in_ready && !out_valid, !out_valid, "result without item")

	`PIDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(drive) && $stable(error_out), "stalled result changed")

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.drive     (result.drive),
	.error_out (result.error_out)
);
